>>> rtl/core/sem_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sem_pkg;

	// Width of each frame size register.
	localparam int unsigned CFG_W = 11;
	// Reset value of both frame size registers.
	localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

	// Register indexes on the configuration port.
	localparam logic REG_FRAME_WIDTH  = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;

	// Input commands.
	localparam logic CMD_PIXEL = 1'b0;
	localparam logic CMD_DRAIN = 1'b1;

	localparam int unsigned PIX_W  = 24;
	localparam int unsigned CH_W   = 8;
	localparam int unsigned GRAD_W = 12;
	localparam int unsigned SUM_W  = 21;
	// The square root is found one bit per cycle over this many bits.
	localparam int unsigned ROOT_W = 11;
	localparam logic [3:0] ROOT_LAST = 4'(ROOT_W - 1);
	localparam logic [ROOT_W:0] MAG_MAX = 12'd255;

	typedef struct packed {
		logic       capture;
		logic       start;
		logic       rd;
		logic       advance;
		logic       grad;
		logic       square;
		logic       root_step;
		logic [3:0] root_idx;
		logic       round;
		logic       emit;
	} sem_cmd_t;

	typedef struct packed {
		logic busy;
		logic is_drain;
		logic in_done;
		logic early;
		logic out_free;
	} sem_stat_t;

endpackage

`default_nettype wire

>>> rtl/core/sobel_edge_magnitude_rgb_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake               Payload
// input     in         in_valid / in_stall     command, in_red, in_green, in_blue
// output    out        out_valid / out_stall   out_red, out_green, out_blue, last_of_frame
// config    in         cfg_we                  cfg_index, cfg_wdata
//
// A word that yields nothing goes back to idle after the check or the window
// update; a word that yields a result then passes gradient, square, the 11-step
// bit-serial square root that runs side by side in the three color lanes, and
// rounding. The next word is taken once the result is loaded, while it still waits.
// arst_n clears the controller, counters and window, and sets both frame size registers to 1024.
// A stall on the output holds the result and blocks only the next result.

module sobel_edge_magnitude_rgb_top #(
	parameter int unsigned MAX_WIDTH  = 1024,
	parameter int unsigned MAX_HEIGHT = 1024
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_stall,
	input  wire logic                      command,
	input  wire logic [7:0]                in_red,
	input  wire logic [7:0]                in_green,
	input  wire logic [7:0]                in_blue,
	output logic                           out_valid,
	input  wire logic                      out_stall,
	output logic [7:0]                     out_red,
	output logic [7:0]                     out_green,
	output logic [7:0]                     out_blue,
	output logic                           last_of_frame,
	input  wire logic                      cfg_we,
	input  wire logic                      cfg_index,
	input  wire logic [sem_pkg::CFG_W-1:0] cfg_wdata
);

	// Commands flow from the controller to the datapath, status flows back.
	sem_pkg::sem_cmd_t  cmd;
	sem_pkg::sem_stat_t stat;

	// The controller sequences one word at a time: capture, check, line store
	// read, window update, then gradient, square, root and rounding.
	sem_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.stat(stat), .cmd(cmd)
	);

	// The datapath holds the line stores, the window, the frame counters and
	// the output register.
	sem_dp #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.command(command), .in_red(in_red), .in_green(in_green), .in_blue(in_blue),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.out_valid(out_valid), .out_stall(out_stall),
		.out_red(out_red), .out_green(out_green), .out_blue(out_blue),
		.last_of_frame(last_of_frame)
	);

endmodule

`default_nettype wire

>>> rtl/core/sem_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module sem_ram #(
	parameter int unsigned WIDTH = 24,
	parameter int unsigned DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/sem_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module sem_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire sem_pkg::sem_stat_t stat,
	output sem_pkg::sem_cmd_t      cmd
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_CHECK, ST_START, ST_READ, ST_WRITE,
		ST_GRAD, ST_SQUARE, ST_ROOT, ST_ROUND, ST_HOLD
	} state_t;

	state_t     state_q;
	logic [3:0] idx_q;

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		cmd           = '0;
		cmd.capture   = (state_q == ST_IDLE) && in_valid;
		cmd.start     = (state_q == ST_START);
		cmd.rd        = (state_q == ST_READ);
		cmd.advance   = (state_q == ST_WRITE);
		cmd.grad      = (state_q == ST_GRAD);
		cmd.square    = (state_q == ST_SQUARE);
		cmd.root_step = (state_q == ST_ROOT);
		cmd.root_idx  = idx_q;
		cmd.round     = (state_q == ST_ROUND);
		cmd.emit      = (state_q == ST_HOLD) && stat.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if (!stat.busy) begin
						state_q <= stat.is_drain ? ST_IDLE : ST_START;
					end else if (stat.is_drain != stat.in_done) begin
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_READ;
					end
				end
				ST_START: state_q <= ST_READ;
				ST_READ:  state_q <= ST_WRITE;
				ST_WRITE: state_q <= stat.early ? ST_IDLE : ST_GRAD;
				ST_GRAD:  state_q <= ST_SQUARE;
				ST_SQUARE: begin
					idx_q   <= '0;
					state_q <= ST_ROOT;
				end
				ST_ROOT: begin
					idx_q <= idx_q + 4'd1;
					if (idx_q == sem_pkg::ROOT_LAST) state_q <= ST_ROUND;
				end
				ST_ROUND: state_q <= ST_HOLD;
				ST_HOLD: begin
					if (stat.out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/sem_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module sem_dp #(
	parameter int unsigned MAX_WIDTH  = 1024,
	parameter int unsigned MAX_HEIGHT = 1024
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire sem_pkg::sem_cmd_t          cmd,
	output sem_pkg::sem_stat_t              stat,
	input  wire logic                       command,
	input  wire logic [7:0]                 in_red,
	input  wire logic [7:0]                 in_green,
	input  wire logic [7:0]                 in_blue,
	input  wire logic                       cfg_we,
	input  wire logic                       cfg_index,
	input  wire logic [sem_pkg::CFG_W-1:0]  cfg_wdata,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic [7:0]                      out_red,
	output logic [7:0]                      out_green,
	output logic [7:0]                      out_blue,
	output logic                            last_of_frame
);

	localparam int unsigned CW = $clog2(MAX_WIDTH);
	localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
	localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);
	localparam int unsigned PW = sem_pkg::PIX_W;
	localparam int unsigned RW = sem_pkg::ROOT_W;

	logic [sem_pkg::CFG_W-1:0] width_q, height_q;
	logic [WW-1:0] act_w_q;
	logic [HW-1:0] act_h_q;
	logic          busy_q;
	logic          cmd_q;
	logic [PW-1:0] pix_q;
	logic [CW-1:0] in_col_q, out_col_q;
	logic [HW-1:0] in_row_q, out_row_q;
	logic [PW-1:0] win_q [3][3];
	logic [PW-1:0] top_rd, mid_rd, new_pix;

	logic signed [sem_pkg::GRAD_W-1:0] gx_q [3];
	logic signed [sem_pkg::GRAD_W-1:0] gy_q [3];
	logic [sem_pkg::SUM_W-1:0] sum_q [3];
	logic [RW-1:0]             root_q [3];
	logic [7:0]                mag_q [3];
	logic                      last_q;

	logic [31:0] cfg_w32, cfg_h32;
	logic [WW-1:0] in_col_next;
	logic          row_wrap;
	logic          out_last;
	logic [WW-1:0] oc_plus;
	logic [HW:0]   r_plus;
	logic          mask_top, mask_bot, mask_left, mask_right;

	assign cfg_w32 = 32'(width_q);
	assign cfg_h32 = 32'(height_q);

	assign new_pix     = (cmd_q == sem_pkg::CMD_PIXEL) ? pix_q : '0;
	assign in_col_next = WW'(in_col_q) + WW'(1);
	assign row_wrap    = (in_col_next >= act_w_q);
	assign oc_plus     = WW'(out_col_q) + WW'(1);
	assign r_plus      = (HW + 1)'(out_row_q) + (HW + 1)'(1);
	assign out_last    = (r_plus == (HW + 1)'(act_h_q)) && (oc_plus == act_w_q);

	assign mask_top   = (out_row_q == '0);
	assign mask_bot   = (r_plus >= (HW + 1)'(act_h_q));
	assign mask_left  = (out_col_q == '0);
	assign mask_right = (oc_plus >= act_w_q);

	assign stat.busy     = busy_q;
	assign stat.is_drain = (cmd_q == sem_pkg::CMD_DRAIN);
	assign stat.in_done  = (in_row_q >= act_h_q);
	assign stat.early    = (in_row_q == '0) || ((in_row_q == HW'(1)) && (in_col_q == '0));
	assign stat.out_free = !out_valid || !out_stall;

	// Row one above (a) and two above (b), read and rewritten at the same column.
	sem_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_line_a (
		.clk(clk), .we(cmd.advance), .waddr(in_col_q), .wdata(new_pix),
		.re(cmd.rd), .raddr(in_col_q), .rdata(mid_rd)
	);
	sem_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_line_b (
		.clk(clk), .we(cmd.advance), .waddr(in_col_q), .wdata(mid_rd),
		.re(cmd.rd), .raddr(in_col_q), .rdata(top_rd)
	);

	// Frame size registers and frame bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q   <= sem_pkg::CFG_RESET;
			height_q  <= sem_pkg::CFG_RESET;
			act_w_q   <= WW'(1);
			act_h_q   <= HW'(1);
			busy_q    <= 1'b0;
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == sem_pkg::REG_FRAME_WIDTH) width_q <= cfg_wdata;
				else height_q <= cfg_wdata;
			end
			if (cmd.start) begin
				if (cfg_w32 == 32'd0) act_w_q <= WW'(1);
				else if (cfg_w32 > 32'(MAX_WIDTH)) act_w_q <= WW'(MAX_WIDTH);
				else act_w_q <= cfg_w32[WW-1:0];
				if (cfg_h32 == 32'd0) act_h_q <= HW'(1);
				else if (cfg_h32 > 32'(MAX_HEIGHT)) act_h_q <= HW'(MAX_HEIGHT);
				else act_h_q <= cfg_h32[HW-1:0];
				busy_q    <= 1'b1;
				in_col_q  <= '0;
				in_row_q  <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
			end
			if (cmd.advance) begin
				if (row_wrap) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + HW'(1);
				end else begin
					in_col_q <= in_col_next[CW-1:0];
				end
			end
			if (out_valid && !out_stall) out_valid <= 1'b0;
			if (cmd.emit) begin
				out_valid <= 1'b1;
				if (last_q) begin
					busy_q    <= 1'b0;
					in_col_q  <= '0;
					in_row_q  <= '0;
					out_col_q <= '0;
					out_row_q <= '0;
				end else if (oc_plus >= act_w_q) begin
					out_col_q <= '0;
					out_row_q <= out_row_q + HW'(1);
				end else begin
					out_col_q <= oc_plus[CW-1:0];
				end
			end
		end
	end

	// 3x3 window, shifted left as each word enters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					win_q[i][j] <= '0;
				end
			end
		end else if (cmd.advance) begin
			for (int i = 0; i < 3; i++) begin
				win_q[i][0] <= win_q[i][1];
				win_q[i][1] <= win_q[i][2];
			end
			win_q[0][2] <= top_rd;
			win_q[1][2] <= mid_rd;
			win_q[2][2] <= new_pix;
		end
	end

	// Arithmetic on the current window, one channel per lane.
	always_ff @(posedge clk) begin
		logic signed [sem_pkg::GRAD_W-1:0] v [3][3];
		logic [RW-1:0]        trial;
		logic [2*RW-1:0]      sq;
		logic [2*RW:0]        lim;
		logic [RW:0]          rounded;
		if (cmd.capture) begin
			cmd_q <= command;
			pix_q <= {in_red, in_green, in_blue};
		end
		for (int c = 0; c < 3; c++) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					v[i][j] = sem_pkg::GRAD_W'(win_q[i][j][(2-c)*8 +: 8]);
				end
			end
			if (mask_top) for (int j = 0; j < 3; j++) v[0][j] = '0;
			if (mask_bot) for (int j = 0; j < 3; j++) v[2][j] = '0;
			if (mask_left) for (int i = 0; i < 3; i++) v[i][0] = '0;
			if (mask_right) for (int i = 0; i < 3; i++) v[i][2] = '0;
			if (cmd.grad) begin
				gx_q[c] <= sem_pkg::GRAD_W'(v[0][2] - v[0][0] + 2 * (v[1][2] - v[1][0])
					+ v[2][2] - v[2][0]);
				gy_q[c] <= sem_pkg::GRAD_W'(v[2][0] - v[0][0] + 2 * (v[2][1] - v[0][1])
					+ v[2][2] - v[0][2]);
			end
			if (cmd.square) begin
				sum_q[c] <= sem_pkg::SUM_W'(gx_q[c] * gx_q[c] + gy_q[c] * gy_q[c]);
				root_q[c] <= '0;
			end
			trial = root_q[c] | (RW'(1) << (sem_pkg::ROOT_LAST - cmd.root_idx));
			sq    = trial * trial;
			if (cmd.root_step && (sq <= (2 * RW)'(sum_q[c]))) root_q[c] <= trial;
			lim     = (2 * RW + 1)'(root_q[c] * root_q[c]) + (2 * RW + 1)'(root_q[c]);
			rounded = (RW + 1)'(root_q[c]) + (((2 * RW + 1)'(sum_q[c]) > lim) ? 1'b1 : 1'b0);
			if (cmd.round) begin
				mag_q[c] <= (rounded > sem_pkg::MAG_MAX) ? 8'd255 : rounded[7:0];
			end
		end
		if (cmd.round) last_q <= out_last;
		if (cmd.emit) begin
			out_red       <= mag_q[0];
			out_green     <= mag_q[1];
			out_blue      <= mag_q[2];
			last_of_frame <= last_q;
		end
	end

endmodule

`default_nettype wire

>>> bench/sobel_edge_magnitude_rgb_checker.sv
`timescale 1ns / 1ps

// Watches both channels and the configuration port of the Sobel block. It keeps
// its own line stores, window and counters, predicts the edge magnitude of each
// word that yields one and compares each result word with the oldest prediction.
module sobel_edge_magnitude_rgb_checker (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	input  wire logic                      in_stall,
	input  wire logic                      command,
	input  wire logic [7:0]                in_red,
	input  wire logic [7:0]                in_green,
	input  wire logic [7:0]                in_blue,
	input  wire logic                      out_valid,
	input  wire logic                      out_stall,
	input  wire logic [7:0]                out_red,
	input  wire logic [7:0]                out_green,
	input  wire logic [7:0]                out_blue,
	input  wire logic                      last_of_frame,
	input  wire logic                      cfg_we,
	input  wire logic                      cfg_index,
	input  wire logic [sem_pkg::CFG_W-1:0] cfg_wdata,
	output int                             errors,
	output int                             pending,
	output int                             checked
);
	import sem_pkg::*;

	localparam int unsigned MAXW = 1024;
	localparam int unsigned MAXH = 1024;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       last;
	} edge_word_t;

	edge_word_t edge_q[$];

	logic [CFG_W-1:0] width_reg, height_reg;
	logic [23:0] row_above[MAXW];
	logic [23:0] row_two_above[MAXW];
	logic [23:0] win[3][3];
	int unsigned col_in, row_in, col_out, row_out, act_w, act_h;
	bit frame_open;

	assign pending = edge_q.size();

	function automatic int unsigned fit_dim(logic [CFG_W-1:0] v, int unsigned maxv);
		if (v == 0) return 1;
		if (v > maxv) return maxv;
		return v;
	endfunction

	// Exact rounded root of the squared gradient, clamped to one byte.
	function automatic logic [7:0] grad_mag(int unsigned sh, bit ok[3][3]);
		int gx, gy, v;
		int unsigned s, f, t;
		gx = 0;
		gy = 0;
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++) begin
				v = ok[i][j] ? int'((win[i][j] >> sh) & 24'hFF) : 0;
				gx += (j - 1) * ((i == 1) ? 2 : 1) * v;
				gy += (i - 1) * ((j == 1) ? 2 : 1) * v;
			end
		s = gx * gx + gy * gy;
		f = 0;
		for (int b = 1024; b != 0; b >>= 1) begin
			t = f | b;
			if (t * t <= s) f = t;
		end
		if (s > f * f + f) f++;
		if (f > 255) f = 255;
		return f[7:0];
	endfunction

	task automatic take_word(logic cmd, logic [23:0] pix);
		int unsigned total, p, c;
		logic [23:0] top, mid, nw;
		bit ok[3][3];
		edge_word_t e;
		if (!frame_open) begin
			if (cmd == CMD_DRAIN) return;
			act_w = fit_dim(width_reg, MAXW);
			act_h = fit_dim(height_reg, MAXH);
			col_in = 0; row_in = 0; col_out = 0; row_out = 0;
			frame_open = 1;
		end
		total = act_w * act_h;
		p = row_in * act_w + col_in;
		if (cmd == CMD_PIXEL && p >= total) return;
		if (cmd == CMD_DRAIN && p < total) return;
		nw = (cmd == CMD_PIXEL) ? pix : 24'd0;
		c = col_in % MAXW;
		top = row_two_above[c];
		mid = row_above[c];
		row_two_above[c] = mid;
		row_above[c] = nw;
		for (int i = 0; i < 3; i++) begin
			win[i][0] = win[i][1];
			win[i][1] = win[i][2];
		end
		win[0][2] = top;
		win[1][2] = mid;
		win[2][2] = nw;
		col_in++;
		if (col_in >= act_w) begin
			col_in = 0;
			row_in++;
		end
		if (p < act_w + 1) return;
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				ok[i][j] = !((i == 0 && row_out == 0) || (i == 2 && row_out + 1 >= act_h) ||
					(j == 0 && col_out == 0) || (j == 2 && col_out + 1 >= act_w));
		e.red = grad_mag(16, ok);
		e.green = grad_mag(8, ok);
		e.blue = grad_mag(0, ok);
		e.last = (row_out + 1 == act_h) && (col_out + 1 == act_w);
		edge_q.push_back(e);
		col_out++;
		if (col_out >= act_w) begin
			col_out = 0;
			row_out++;
		end
		if (e.last) frame_open = 0;
	endtask

	task automatic report(string what);
		errors++;
		if (errors <= 30) $display("%0t mismatch: %s", $realtime, what);
	endtask

	always @(posedge clk or negedge arst_n) begin
		edge_word_t e;
		if (!arst_n) begin
			width_reg <= CFG_RESET;
			height_reg <= CFG_RESET;
			for (int i = 0; i < MAXW; i++) begin
				row_above[i] = '0;
				row_two_above[i] = '0;
			end
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++) win[i][j] = '0;
			frame_open = 0;
			edge_q.delete();
		end else begin
			if (out_valid && !out_stall) begin
				checked++;
				if (edge_q.size() == 0) begin
					report("result word with nothing expected");
				end else begin
					e = edge_q.pop_front();
					if (out_red !== e.red)
						report($sformatf("red %0d, expected %0d", out_red, e.red));
					if (out_green !== e.green)
						report($sformatf("green %0d, expected %0d", out_green, e.green));
					if (out_blue !== e.blue)
						report($sformatf("blue %0d, expected %0d", out_blue, e.blue));
					if (last_of_frame !== e.last)
						report($sformatf("last_of_frame %b, expected %b", last_of_frame, e.last));
				end
			end
			if (in_valid && !in_stall)
				take_word(command, {in_red, in_green, in_blue});
			if (cfg_we) begin
				if (cfg_index == REG_FRAME_WIDTH) width_reg <= cfg_wdata;
				else width_reg <= width_reg;
				if (cfg_index == REG_FRAME_HEIGHT) height_reg <= cfg_wdata;
			end
		end
	end

	initial begin
		errors = 0;
		checked = 0;
	end

endmodule

>>> bench/sobel_edge_magnitude_rgb_top_test.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the Sobel edge magnitude block. Frames of many sizes
// are streamed in raster order, followed by the drain words that push out the
// last row and pixel. Early drains, stray pixels while draining and extra drains
// after the end of a frame are mixed in as noise. All checking lives in the
// checker module instantiated next to the block.
module sobel_edge_magnitude_rgb_top_test;
	import sem_pkg::*;

	logic clk, arst_n;
	logic in_valid, command;
	logic [7:0] in_red, in_green, in_blue;
	logic in_stall;
	logic out_valid, out_stall;
	logic [7:0] out_red, out_green, out_blue;
	logic last_of_frame;
	logic cfg_we, cfg_index;
	logic [CFG_W-1:0] cfg_wdata;

	int errors, pending, checked;
	int words_sent, frames_sent;
	int unsigned cycles;
	// When set, neither side idles nor stalls.
	bit quiet;

	sobel_edge_magnitude_rgb_top i_dut (.*);

	sobel_edge_magnitude_rgb_checker i_checker (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// The result side stalls at random, with a chance of 6 in 100 on each clock edge, unless quiet is set.
	always @(posedge clk)
		out_stall <= !quiet && ($urandom_range(99) < 6);

	// The run is cut off if it hangs.
	always @(posedge clk) begin
		cycles++;
		if (cycles > 1000000) begin
			$display("timeout after %0d cycles", cycles);
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Sends one word. The valid stays high from one word to the next unless the
	// sender decides to idle first. The stall is sampled at the falling edge,
	// where it is stable, to decide whether the next rising edge accepts.
	task automatic send_word(logic cmd, logic [7:0] r, logic [7:0] g, logic [7:0] b);
		bit stalled;
		if (!quiet && $urandom_range(99) < 6) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < 40);
		end
		in_valid <= 1'b1;
		command <= cmd;
		in_red <= r;
		in_green <= g;
		in_blue <= b;
		do begin
			@(negedge clk);
			stalled = in_stall;
			@(posedge clk);
		end while (stalled);
		words_sent++;
	endtask

	function automatic logic [7:0] chan_value();
		case ($urandom_range(9))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic send_pixel();
		send_word(CMD_PIXEL, chan_value(), chan_value(), chan_value());
	endtask

	task automatic send_drain();
		send_word(CMD_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom));
	endtask

	// Waits until every expected word has come back and the block has settled.
	// The first edge lets the checker record the last accepted word.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	// Writes the frame width register and then the frame height register.
	task automatic write_size(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
		cfg_we <= 1'b1;
		cfg_index <= REG_FRAME_WIDTH;
		cfg_wdata <= w;
		@(posedge clk);
		cfg_index <= REG_FRAME_HEIGHT;
		cfg_wdata <= h;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// One whole frame. With noise set, early drains, pixels after the last pixel
	// and drains after the final result are mixed in; none of them yields a word.
	task automatic run_frame(logic [CFG_W-1:0] w_reg, logic [CFG_W-1:0] h_reg, bit noise);
		int unsigned w, h, total, drains;
		w = (w_reg == 0) ? 1 : (w_reg > 1024) ? 1024 : w_reg;
		h = (h_reg == 0) ? 1 : (h_reg > 1024) ? 1024 : h_reg;
		total = w * h;
		drains = (total < w + 1) ? total : w + 1;
		for (int unsigned k = 0; k < total; k++) begin
			if (noise && k != 0 && $urandom_range(99) < 3) send_drain();
			send_pixel();
		end
		for (int unsigned k = 0; k < drains; k++) begin
			if (noise && $urandom_range(99) < 8) send_pixel();
			send_drain();
		end
		if (noise && $urandom_range(99) < 30) send_drain();
		frames_sent++;
	endtask

	initial begin
		logic [CFG_W-1:0] w, h;
		arst_n = 0;
		in_valid = 0;
		command = CMD_PIXEL;
		in_red = 0;
		in_green = 0;
		in_blue = 0;
		out_stall = 0;
		cfg_we = 0;
		cfg_index = REG_FRAME_WIDTH;
		cfg_wdata = '0;
		cycles = 0;
		words_sent = 0;
		frames_sent = 0;
		quiet = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed part. A drain with no frame open gives nothing.
		send_drain();
		// A single-pixel frame: its only result comes from a drain.
		settle();
		write_size(11'd1, 11'd1);
		send_word(CMD_PIXEL, 8'd255, 8'd0, 8'd255);
		send_drain();
		send_drain();
		// A 3x3 checkerboard of extremes. The size registers are rewritten
		// partway, which must only take effect at the next frame.
		settle();
		write_size(11'd3, 11'd3);
		for (int k = 0; k < 4; k++)
			send_word(CMD_PIXEL, (k % 2) ? 8'd255 : 8'd0, (k % 2) ? 8'd0 : 8'd255, 8'd255);
		settle();
		write_size(11'd2, 11'd2);
		for (int k = 4; k < 9; k++) begin
			if (k == 6) send_drain();
			send_word(CMD_PIXEL, (k % 2) ? 8'd255 : 8'd0, (k % 2) ? 8'd0 : 8'd255, 8'd0);
		end
		send_drain();
		send_word(CMD_PIXEL, 8'd255, 8'd255, 8'd255);
		for (int k = 0; k < 3; k++) send_drain();
		// The 2x2 size written mid-frame applies now.
		run_frame(11'd2, 11'd2, 0);

		// Out-of-range sizes: zero acts as one, anything above the maximum as
		// the maximum. The one-column frame of full height is the largest of
		// the run.
		settle();
		write_size(11'd5, 11'd0);
		run_frame(11'd5, 11'd0, 0);
		settle();
		write_size(11'd0, 11'd2047);
		run_frame(11'd0, 11'd2047, 1);

		// Random frames, mostly small, with a stretch of frames without idling.
		for (int f = 0; words_sent < 1350; f++) begin
			quiet = (f >= 8 && f < 16);
			if (f == 0 || $urandom_range(99) < 80) begin
				settle();
				w = ($urandom_range(9) == 0) ? 11'($urandom_range(40, 13))
					: 11'($urandom_range(12, 1));
				h = 11'($urandom_range(6, 1));
				write_size(w, h);
			end
			run_frame(w, h, $urandom_range(99) < 60);
		end

		in_valid <= 1'b0;
		quiet = 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		$display("Covered %0d frames in %0d input words, %0d result words checked.",
			frames_sent, words_sent, checked);
		$display("Sizes ranged from one pixel to a full column, with noise words.");
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

>>> filelist.f
rtl/core/sem_pkg.sv
rtl/core/sem_ram.sv
rtl/core/sem_ctrl.sv
rtl/core/sem_dp.sv
rtl/core/sobel_edge_magnitude_rgb_top.sv
bench/sobel_edge_magnitude_rgb_checker.sv
bench/sobel_edge_magnitude_rgb_top_test.sv
